// ===== hdl/dllm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and command codes for the doubly linked list manager.
package dllm_pkg;

    localparam logic [1:0] CMD_INS_HEAD = 2'd0;
    localparam logic [1:0] CMD_APP_TAIL = 2'd1;
    localparam logic [1:0] CMD_REMOVE   = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] item_slot;
        logic [1:0] target_list;
    } t_dllm_cmd;

    typedef struct packed {
        logic       ok;
        logic [1:0] affected_list;
        logic       head_valid;
        logic [5:0] head_slot;
        logic [5:0] tail_slot;
        logic [6:0] list_length;
    } t_dllm_res;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_EXEC2
    } t_dllm_state;

endpackage

// ===== hdl/doubly_linked_list_manager_unit.sv =====
`timescale 1ns / 1ps
// Doubly linked list manager: link memories, list table and command sequencer.
// Result: the result strobe is registered from the EXEC state, or from EXEC2 when a
// command needs a second link write (inserts into non-empty lists).
// Commands do not overlap: a new one is taken only in IDLE, as each link RAM has a single write port.
// Reset: clears lists and config, then sweeps every owner RAM entry to zero (busy high).
// The receiver cannot stall: o_res_valid is high for exactly one cycle per result word.
module doubly_linked_list_manager_unit
    import dllm_pkg::*;
#(
    parameter int NUM_SLOTS = 64,
    parameter int NUM_LISTS = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_dllm_cmd i_cmd,
    output logic      o_res_valid,
    output t_dllm_res o_result,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    localparam int SW  = $clog2(NUM_SLOTS);
    localparam int LW  = $clog2(NUM_SLOTS + 1);
    localparam int LLW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int OW  = $clog2(NUM_LISTS + 1);

    t_dllm_state r_state, n_state;

    logic           r_circ;
    logic [1:0]     r_cmd;
    logic [SW-1:0]  r_slot;
    logic [1:0]     r_tgt;
    logic           r_slot_ok;
    logic           r_list_ok;
    logic [SW-1:0]  r_clr_cnt;

    logic           r_lhv  [NUM_LISTS];
    logic [SW-1:0]  r_lh   [NUM_LISTS];
    logic           r_ltv  [NUM_LISTS];
    logic [SW-1:0]  r_lt   [NUM_LISTS];
    logic [LW-1:0]  r_llen [NUM_LISTS];

    logic           r_w2n_en, n_w2n_en;
    logic [SW-1:0]  r_w2n_a, n_w2n_a, r_w2n_d, n_w2n_d;
    logic           r_w2p_en, n_w2p_en;
    logic [SW-1:0]  r_w2p_a, n_w2p_a, r_w2p_d, n_w2p_d;

    logic           r_res_vld, n_res_vld;
    t_dllm_res      r_res, n_res;

    // list table update
    logic           n_lhv, n_ltv, l_wr;
    logic [SW-1:0]  n_lh, n_lt;
    logic [LW-1:0]  n_llen;

    // RAM ports
    logic           nx_we, pv_we, ow_we;
    logic [SW-1:0]  nx_wa, nx_wd, pv_wa, pv_wd, ow_wa;
    logic [OW-1:0]  ow_wd;
    logic [SW-1:0]  nx_ra, slot_ra;
    logic [SW-1:0]  nx_rd, pv_rd;
    logic [OW-1:0]  ow_rd;

    // execute stage
    logic           w1n_en, w1p_en;
    logic [SW-1:0]  w1n_a, w1n_d, w1p_a, w1p_d;
    logic           w1o_en;
    logic [OW-1:0]  w1o_d;
    logic           ins_ok, rem_ok, res_ok, need_w2;
    logic [LLW-1:0] tgt_l, own_l, lsel;
    logic           c_hv, c_tv;
    logic [SW-1:0]  c_h, c_t;
    logic [LW-1:0]  c_len;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_vld;
    assign o_result    = r_res;

    assign slot_ra = SW'(i_cmd.item_slot);
    assign nx_ra   = (i_cmd.cmd != CMD_REMOVE && r_circ) ? r_lh[LLW'(i_cmd.target_list)]
                                                         : slot_ra;

    dllm_ram #(.DW(SW), .DEPTH(NUM_SLOTS)) u_next_ram (
        .i_clk  (i_clk),
        .i_we   (nx_we),
        .i_waddr(nx_wa),
        .i_wdata(nx_wd),
        .i_raddr(nx_ra),
        .o_rdata(nx_rd)
    );

    dllm_ram #(.DW(SW), .DEPTH(NUM_SLOTS)) u_prev_ram (
        .i_clk  (i_clk),
        .i_we   (pv_we),
        .i_waddr(pv_wa),
        .i_wdata(pv_wd),
        .i_raddr(slot_ra),
        .o_rdata(pv_rd)
    );

    dllm_ram #(.DW(OW), .DEPTH(NUM_SLOTS)) u_owner_ram (
        .i_clk  (i_clk),
        .i_we   (ow_we),
        .i_waddr(ow_wa),
        .i_wdata(ow_wd),
        .i_raddr(slot_ra),
        .o_rdata(ow_rd)
    );

    // write port steering
    always_comb begin
        nx_we = 1'b0;
        nx_wa = w1n_a;
        nx_wd = w1n_d;
        pv_we = 1'b0;
        pv_wa = w1p_a;
        pv_wd = w1p_d;
        ow_we = 1'b0;
        ow_wa = r_slot;
        ow_wd = w1o_d;
        case (r_state)
            S_CLEAR: begin
                ow_we = 1'b1;
                ow_wa = r_clr_cnt;
                ow_wd = '0;
            end
            S_EXEC: begin
                nx_we = w1n_en;
                pv_we = w1p_en;
                ow_we = w1o_en;
            end
            S_EXEC2: begin
                nx_we = r_w2n_en;
                nx_wa = r_w2n_a;
                nx_wd = r_w2n_d;
                pv_we = r_w2p_en;
                pv_wa = r_w2p_a;
                pv_wd = r_w2p_d;
            end
            default: begin
            end
        endcase
    end

    // command evaluation
    assign tgt_l  = LLW'(r_tgt);
    assign own_l  = LLW'(ow_rd - OW'(1));
    assign ins_ok = r_slot_ok && r_list_ok && (r_cmd == CMD_INS_HEAD || r_cmd == CMD_APP_TAIL)
                    && (ow_rd == '0);
    assign rem_ok = r_slot_ok && (r_cmd == CMD_REMOVE) && (ow_rd != '0)
                    && (32'(ow_rd) <= NUM_LISTS);
    assign lsel   = rem_ok ? own_l : tgt_l;
    assign c_hv   = r_lhv[lsel];
    assign c_h    = r_lh[lsel];
    assign c_tv   = r_ltv[lsel];
    assign c_t    = r_lt[lsel];
    assign c_len  = r_llen[lsel];
    assign res_ok = ins_ok || rem_ok;

    always_comb begin
        n_lhv    = c_hv;
        n_lh     = c_h;
        n_ltv    = c_tv;
        n_lt     = c_t;
        n_llen   = c_len;
        l_wr     = res_ok;
        w1n_en   = 1'b0;
        w1n_a    = r_slot;
        w1n_d    = r_slot;
        w1p_en   = 1'b0;
        w1p_a    = r_slot;
        w1p_d    = r_slot;
        w1o_en   = res_ok;
        w1o_d    = '0;
        n_w2n_en = 1'b0;
        n_w2n_a  = r_slot;
        n_w2n_d  = r_slot;
        n_w2p_en = 1'b0;
        n_w2p_a  = r_slot;
        n_w2p_d  = r_slot;
        if (ins_ok) begin
            w1o_d  = OW'(tgt_l) + OW'(1);
            n_llen = c_len + LW'(1);
            if (r_circ) begin
                if (c_hv) begin
                    w1n_en   = 1'b1;
                    w1n_a    = c_h;
                    w1p_en   = 1'b1;
                    w1p_a    = nx_rd;
                    n_w2n_en = 1'b1;
                    n_w2n_d  = nx_rd;
                    n_w2p_en = 1'b1;
                    n_w2p_d  = c_h;
                end else begin
                    w1n_en = 1'b1;
                    w1p_en = 1'b1;
                    n_lhv  = 1'b1;
                    n_lh   = r_slot;
                end
            end else if (r_cmd == CMD_INS_HEAD) begin
                n_lhv = 1'b1;
                n_lh  = r_slot;
                if (c_hv) begin
                    w1n_en   = 1'b1;
                    w1n_d    = c_h;
                    w1p_en   = 1'b1;
                    w1p_a    = c_h;
                    n_w2p_en = 1'b1;
                end else begin
                    w1n_en = 1'b1;
                    w1p_en = 1'b1;
                    n_ltv  = 1'b1;
                    n_lt   = r_slot;
                end
            end else begin
                n_ltv = 1'b1;
                n_lt  = r_slot;
                if (c_tv) begin
                    w1p_en   = 1'b1;
                    w1p_d    = c_t;
                    w1n_en   = 1'b1;
                    w1n_a    = c_t;
                    n_w2n_en = 1'b1;
                end else begin
                    w1n_en = 1'b1;
                    w1p_en = 1'b1;
                    n_lhv  = 1'b1;
                    n_lh   = r_slot;
                end
            end
        end else if (rem_ok) begin
            if (c_len != '0) begin
                n_llen = c_len - LW'(1);
            end
            w1n_a = pv_rd;
            w1n_d = nx_rd;
            w1p_a = nx_rd;
            w1p_d = pv_rd;
            if (r_circ) begin
                w1n_en = 1'b1;
                w1p_en = 1'b1;
                if (c_len <= LW'(1)) begin
                    n_lhv = 1'b0;
                end else if (c_hv && c_h == r_slot) begin
                    n_lh = pv_rd;
                end
            end else begin
                w1p_en = !(c_tv && c_t == r_slot);
                w1n_en = !(c_hv && c_h == r_slot);
                if (c_hv && c_h == r_slot) begin
                    n_lhv = !(c_tv && c_t == r_slot);
                    n_lh  = nx_rd;
                end
                if (c_tv && c_t == r_slot) begin
                    n_ltv = !(c_hv && c_h == r_slot);
                    n_lt  = pv_rd;
                end
            end
        end
    end

    assign need_w2 = n_w2n_en || n_w2p_en;

    // result word
    always_comb begin
        n_res               = '0;
        n_res.ok            = res_ok;
        n_res.affected_list = rem_ok ? 2'(own_l) : r_tgt;
        if (res_ok || r_list_ok) begin
            n_res.head_valid  = res_ok ? n_lhv : c_hv;
            n_res.head_slot   = n_res.head_valid ? 6'(res_ok ? n_lh : c_h) : 6'd0;
            n_res.tail_slot   = (!r_circ && (res_ok ? n_ltv : c_tv))
                                ? 6'(res_ok ? n_lt : c_t) : 6'd0;
            n_res.list_length = 7'(res_ok ? n_llen : c_len);
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_res_vld = 1'b0;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == SW'(NUM_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (need_w2) begin
                    n_state = S_EXEC2;
                end else begin
                    n_state   = S_IDLE;
                    n_res_vld = 1'b1;
                end
            end
            S_EXEC2: begin
                n_state   = S_IDLE;
                n_res_vld = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_res_vld <= 1'b0;
            r_circ    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_res_vld <= n_res_vld;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + SW'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_circ <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_lhv[i]  <= 1'b0;
                r_ltv[i]  <= 1'b0;
                r_llen[i] <= '0;
            end
        end else if (r_state == S_EXEC && l_wr) begin
            r_lhv[lsel]  <= n_lhv;
            r_ltv[lsel]  <= n_ltv;
            r_llen[lsel] <= n_llen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && l_wr) begin
            r_lh[lsel] <= n_lh;
            r_lt[lsel] <= n_lt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_cmd     <= i_cmd.cmd;
            r_slot    <= SW'(i_cmd.item_slot);
            r_tgt     <= i_cmd.target_list;
            r_slot_ok <= (32'(i_cmd.item_slot) < NUM_SLOTS);
            r_list_ok <= (32'(i_cmd.target_list) < NUM_LISTS);
        end
        if (r_state == S_EXEC) begin
            r_res    <= n_res;
            r_w2n_en <= n_w2n_en;
            r_w2n_a  <= n_w2n_a;
            r_w2n_d  <= n_w2n_d;
            r_w2p_en <= n_w2p_en;
            r_w2p_a  <= n_w2p_a;
            r_w2p_d  <= n_w2p_d;
        end
    end

endmodule

// ===== hdl/dllm_ram.sv =====
`timescale 1ns / 1ps
// Single write port, single read port RAM with registered read data.
module dllm_ram #(
    parameter int DW    = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
